### hw/rtl/sha256_compression_rounds_macros.svh
// Assertion macros shared by the SHA-256 round block.
`ifndef SHA256_COMPRESSION_ROUNDS_MACROS_SVH
`define SHA256_COMPRESSION_ROUNDS_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sha256cr_pkg.sv
// Types and constants of the SHA-256 round block.
`timescale 1ns / 1ps

package sha256cr_pkg;

  localparam int unsigned ROUNDS     = 64;
  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [5:0] LAST_ROUND  = 6'(ROUNDS - 1);
  localparam logic [2:0] LAST_DIGEST = 3'(HASH_WORDS - 1);

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] schedule_word;
    logic        new_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_word;
  } out_word_t;

  // One classified round as it waits in the queue: K[t] + W[t] already summed.
  typedef struct packed {
    logic [31:0] kw;
    logic        new_message;
    logic        last_round;
  } round_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hw/rtl/sha256cr_front.sv
// Front end: numbers each incoming word by round and folds in the round constant.
`timescale 1ns / 1ps

module sha256cr_front import sha256cr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  in_word_t     in_word_i,
  input  q_stat_t      q_stat_i,
  output logic         push_o,
  output round_entry_t push_data_o
);

  logic [5:0] round_q, round_d;
  logic [5:0] round_idx;

  // A new message restarts numbering at round 0 with this word.
  assign round_idx  = in_word_i.new_message ? 6'd0 : round_q;
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  assign push_data_o.kw          = ROUND_K[round_idx] + in_word_i.schedule_word;
  assign push_data_o.new_message = in_word_i.new_message;
  assign push_data_o.last_round  = (round_idx == LAST_ROUND);

  assign round_d = push_o ? round_idx + 6'd1 : round_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= '0;
    end else begin
      round_q <= round_d;
    end
  end

endmodule

### hw/rtl/sha256cr_fifo.sv
// Short queue that decouples the front end from the round engine.
`timescale 1ns / 1ps

module sha256cr_fifo import sha256cr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  round_entry_t push_data_i,
  input  logic         pop_i,
  output round_entry_t head_o,
  output q_stat_t      stat_o
);

  round_entry_t mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/sha256cr_back.sv
// Round engine: working variables, chaining hash and the digest output buffer.
`timescale 1ns / 1ps

module sha256cr_back import sha256cr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  round_entry_t head_i,
  input  q_stat_t      q_stat_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output out_word_t    out_word_o
);

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] wv_q    [HASH_WORDS];
  logic [31:0] wv_d    [HASH_WORDS];
  logic [31:0] chain_q [HASH_WORDS];
  logic [31:0] chain_d [HASH_WORDS];
  logic [31:0] dig_q   [HASH_WORDS];
  logic [31:0] cur     [HASH_WORDS];
  logic [31:0] hsum    [HASH_WORDS];

  logic        fin_q, fin_d;
  logic        busy_q, busy_d;
  logic [2:0]  idx_q, idx_d;
  logic        out_take;
  logic [31:0] s1, ch, s0, mj, t1, t2;

  // A final round may only leave the queue once the digest buffer is free.
  assign pop_o = !q_stat_i.empty && !fin_q && (!head_i.last_round || !busy_q);

  assign out_valid_o             = busy_q;
  assign out_word_o.digest_word  = dig_q[idx_q];
  assign out_word_o.digest_index = idx_q;
  assign out_word_o.last_word    = (idx_q == LAST_DIGEST);
  assign out_take                = busy_q && !out_stall_i;

  always_comb begin
    for (int i = 0; i < HASH_WORDS; i++) begin
      cur[i]  = head_i.new_message ? INIT_HASH[i] : wv_q[i];
      hsum[i] = chain_q[i] + wv_q[i];
    end
    s1 = rotr(cur[4], 6) ^ rotr(cur[4], 11) ^ rotr(cur[4], 25);
    ch = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
    s0 = rotr(cur[0], 2) ^ rotr(cur[0], 13) ^ rotr(cur[0], 22);
    mj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
    t1 = cur[7] + s1 + ch + head_i.kw;
    t2 = s0 + mj;
  end

  always_comb begin
    wv_d    = wv_q;
    chain_d = chain_q;
    fin_d   = fin_q;
    busy_d  = busy_q;
    idx_d   = idx_q;

    if (out_take) begin
      idx_d = idx_q + 3'd1;
      if (idx_q == LAST_DIGEST) begin
        busy_d = 1'b0;
      end
    end

    if (fin_q) begin
      // The block's 64 rounds are done: fold into the chaining hash.
      wv_d    = hsum;
      chain_d = hsum;
      fin_d   = 1'b0;
      busy_d  = 1'b1;
      idx_d   = '0;
    end else if (pop_o) begin
      if (head_i.new_message) begin
        chain_d = INIT_HASH;
      end
      for (int i = HASH_WORDS - 1; i > 0; i--) begin
        wv_d[i] = cur[i-1];
      end
      wv_d[0] = t1 + t2;
      wv_d[4] = cur[3] + t1;
      fin_d   = head_i.last_round;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q    <= INIT_HASH;
      chain_q <= INIT_HASH;
      fin_q   <= 1'b0;
      busy_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      wv_q    <= wv_d;
      chain_q <= chain_d;
      fin_q   <= fin_d;
      busy_q  <= busy_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      dig_q <= hsum;
    end
  end

endmodule

### hw/rtl/sha256_compression_rounds.sv
// Channel   Direction  Word        Fields
// in        input      in_word_i   schedule_word, new_message
// out       output     out_word_o  digest_word, digest_index, last_word
//
// One schedule word is taken per cycle, unless the queue is full, into a four-entry
// word queue. A block of 64 words runs its rounds in the round engine, then a further
// step adds the working variables into the chaining hash, during which no word
// leaves the queue. The eight digest words leave one per cycle, unless the output
// stalls, from a buffer while the next block's rounds proceed. Reset loads the
// initial hash and empties the queue; an output stall holds the rounds back only
// when a block's final round arrives before the previous digest has drained.
`timescale 1ns / 1ps
`include "sha256_compression_rounds_macros.svh"

module sha256_compression_rounds import sha256cr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic         push;
  logic         pop;
  round_entry_t push_data;
  round_entry_t head;
  q_stat_t      q_stat;

  sha256cr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sha256cr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  sha256cr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  `SHA_ASSERT_NOW(a_digest_starts_at_h0, $rose(out_valid_o), out_word_o.digest_index == 3'd0, "digest run does not start at H0")
  `SHA_ASSERT_NEXT(a_digest_in_order, out_valid_o && !out_stall_i && !out_word_o.last_word, out_valid_o && out_word_o.digest_index == $past(out_word_o.digest_index) + 3'd1, "digest words out of order")
  `SHA_ASSERT_NOW(a_queue_sane, q_stat.full, !q_stat.empty && !pop || !q_stat.empty, "queue full and empty at once")

endmodule

### test/tb_sha256_compression_rounds.sv
// Self-checking testbench for the SHA-256 round block: random schedule words, digest scoreboard.
`timescale 1ns / 1ps

module tb_sha256_compression_rounds;
  import sha256cr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam logic [5:0] FINAL_ROUND = 6'd63;
  localparam logic [2:0] FINAL_INDEX = 3'd7;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_START [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  in_word_t    sched_q [$];
  out_word_t   digest_q [$];
  logic [31:0] chain_h [8];
  logic [31:0] work_v [8];
  logic [5:0]  round_no;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;

  sha256_compression_rounds dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression round on the predicted state; after the final round the
  // updated chaining hash is queued as eight expected digest words.
  function automatic void sha_round(in_word_t w);
    logic [31:0] s1, ch, s0, mj, t1, t2;
    out_word_t d;
    if (w.new_message) begin
      chain_h = H_START;
      work_v = H_START;
      round_no = '0;
    end
    s1 = ror32(work_v[4], 6) ^ ror32(work_v[4], 11) ^ ror32(work_v[4], 25);
    ch = (work_v[4] & work_v[5]) ^ (~work_v[4] & work_v[6]);
    s0 = ror32(work_v[0], 2) ^ ror32(work_v[0], 13) ^ ror32(work_v[0], 22);
    mj = (work_v[0] & work_v[1]) ^ (work_v[0] & work_v[2]) ^ (work_v[1] & work_v[2]);
    t1 = work_v[7] + s1 + ch + SHA_K[round_no] + w.schedule_word;
    t2 = s0 + mj;
    for (int i = 7; i > 0; i--) work_v[i] = work_v[i - 1];
    work_v[0] = t1 + t2;
    work_v[4] = work_v[4] + t1;
    if (round_no == FINAL_ROUND) begin
      for (int i = 0; i < 8; i++) begin
        chain_h[i] = chain_h[i] + work_v[i];
        work_v[i] = chain_h[i];
        d.digest_word = chain_h[i];
        d.digest_index = 3'(i);
        d.last_word = (3'(i) == FINAL_INDEX);
        digest_q.push_back(d);
      end
    end
    round_no = round_no + 6'd1;
  endfunction

  // Mostly uniform words, with all-zero, all-one and one-hot values mixed in.
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hffffffff;
    if (r == 2) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  task automatic push_sched(logic [31:0] w, logic restart);
    in_word_t it;
    it.schedule_word = w;
    it.new_message = restart;
    sched_q.push_back(it);
  endtask

  task automatic push_block(logic restart);
    push_sched(pick_word(), restart);
    for (int i = 1; i < 64; i++) push_sched(pick_word(), 1'b0);
  endtask

  // Mostly complete 64-word blocks, some continuing the previous message;
  // the rest are runs of random length from 1 to 70 words with restarts scattered through them.
  task automatic push_random(int unsigned n_items);
    int unsigned added, len;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        push_block(1'($urandom_range(0, 1)));
        added += 64;
      end else begin
        len = $urandom_range(1, 70);
        for (int i = 0; i < len; i++)
          push_sched(pick_word(), $urandom_range(0, 99) < 6);
        added += len;
      end
    end
  endtask

  task automatic wait_sender_done();
    while (sched_q.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  // Input side: a held word stays put until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) sha_round(in_word_i);
      if (!in_valid_i || !in_stall_o) begin
        if (sched_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_word_i <= sched_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: compare each digest word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h index %0d", out_word_o.digest_word,
                 out_word_o.digest_index);
          fail_cnt++;
        end else begin
          want = digest_q.pop_front();
          if (out_word_o.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word,
                   out_word_o.digest_word);
            fail_cnt++;
          end
          if (out_word_o.digest_index !== want.digest_index) begin
            $error("digest_index: expected %0d, got %0d", want.digest_index,
                   out_word_o.digest_index);
            fail_cnt++;
          end
          if (out_word_o.last_word !== want.last_word) begin
            $error("last_word: expected %0b, got %0b", want.last_word,
                   out_word_o.last_word);
            fail_cnt++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    chain_h = H_START;
    work_v = H_START;
    round_no = '0;

    // Directed: opening rounds straight after reset without a restart, field
    // extremes, a restart in mid-block and two restarts back to back.
    push_sched(32'h00000000, 1'b0);
    push_sched(32'hffffffff, 1'b0);
    push_sched(32'h80000000, 1'b0);
    push_sched(32'h00000001, 1'b0);
    push_sched(32'haaaaaaaa, 1'b0);
    push_sched(32'h55555555, 1'b0);
    push_sched(32'hffffffff, 1'b1);
    push_sched(32'h00000000, 1'b0);
    push_sched(32'hffffffff, 1'b0);
    push_sched(32'h00000000, 1'b1);
    push_sched(32'hffffffff, 1'b1);
    push_sched(32'h7fffffff, 1'b0);
    push_sched(32'hfffffffe, 1'b0);
    push_sched(32'h0000ffff, 1'b0);
    push_sched(32'hffff0000, 1'b0);
    push_sched(32'h12345678, 1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_sender_done();
    push_random(45);
    wait_sender_done();

    send_idle_pct = 88;
    push_random(45);
    wait_sender_done();

    send_idle_pct = 0;
    recv_stall_pct = 88;
    push_random(45);
    wait_sender_done();

    send_idle_pct = 29;
    recv_stall_pct = 29;
    push_random(50);
    wait_sender_done();

    // Long output hold while full blocks keep coming, so the block backs up.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 2; i++) push_block(i == 0);
    hold_left = HOLD_CYCLES;
    wait_sender_done();

    while (digest_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
